// File: rtl/core/ftws_pkg.sv
// Package for the frame time window statistics block.
// Holds field widths, action codes, controller states and the ctrl/datapath structs.
// No dependencies.
package ftws_pkg;

	localparam int ACTION_W     = 2;
	localparam int DUR_W        = 32;
	localparam int TOTAL_W      = 40;
	localparam int CALLS_W      = 16;
	localparam int FILL_W       = 6;
	localparam int OUT_DATA_W   = 176;
	localparam int WINDOW_DEPTH_DEF = 60;

	typedef enum logic [ACTION_W-1:0] {
		ACT_RECORD = 2'd0,
		ACT_START  = 2'd1,
		ACT_END    = 2'd2,
		ACT_CLEAR  = 2'd3
	} ftws_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_BUSY,
		ST_EMIT
	} ftws_state_t;

	typedef struct packed {
		logic exec;      // apply the accepted beat to the frame/window state
		logic push;      // push frame total into the window
		logic start;     // kick off window max scan and average divide
		logic load_avg;  // capture the divider quotient
		logic load_out;  // load the output register
	} ftws_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
	} ftws_stat_t;

endpackage

// File: rtl/core/ftws_div.sv
// Restoring divider, one quotient bit per cycle.
// Used for the window average. Depends on nothing but its parameters.
module ftws_div #(
	parameter int DW = 46,
	parameter int VW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);
	localparam int SW = $clog2(DW + 1);

	logic [SW-1:0] steps_q;
	logic [DW-1:0] num_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] den_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;

	assign trial = {rem_q[VW-1:0], num_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= SW'(DW);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (steps_q != '0) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy     = (steps_q != '0);
	assign quotient = quo_q;

endmodule

// File: rtl/core/ftws_ctrl.sv
// Controller for the frame time window statistics block.
// Sequences accept, window update, scan/divide and result load. Uses ftws_pkg.
module ftws_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  ftws_pkg::ftws_stat_t stat,
	output ftws_pkg::ftws_cmd_t  cmd
);
	import ftws_pkg::*;

	ftws_state_t state_q, state_d;
	logic        enable_q;
	logic        m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					if (ftws_action_t'(s_tuser) == ACT_END && enable_q) begin
						cmd.push = 1'b1;
						state_d  = ST_START;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_BUSY;
			end
			ST_BUSY: begin
				if (stat.scan_done && stat.div_done) begin
					cmd.load_avg = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: rtl/core/ftws_dp.sv
// Datapath for the frame time window statistics block.
// Frame counters, window store and sum, max scan, divider, output register.
// Uses ftws_pkg and ftws_div.
module ftws_dp #(
	parameter int WINDOW_DEPTH = ftws_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ftws_pkg::ACTION_W-1:0]   action,
	input  logic [ftws_pkg::DUR_W-1:0]      duration_ns,
	input  ftws_pkg::ftws_cmd_t             cmd,
	output ftws_pkg::ftws_stat_t            stat,
	output logic [ftws_pkg::OUT_DATA_W-1:0] out_data
);
	import ftws_pkg::*;

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SW = TOTAL_W + CW;
	localparam logic [CW:0]   DEPTH_X    = (CW + 1)'(WINDOW_DEPTH);
	localparam logic [CW-1:0] DEPTH_C    = CW'(WINDOW_DEPTH);
	localparam logic [IW-1:0] LAST_IDX   = IW'(WINDOW_DEPTH - 1);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [CALLS_W-1:0] CALLS_MAX = '1;

	// frame counters
	logic [TOTAL_W-1:0] total_q;
	logic [DUR_W-1:0]   fmax_q;
	logic [CALLS_W-1:0] calls_q;
	logic [TOTAL_W:0]   total_sum;

	// window state
	logic [TOTAL_W-1:0] mem [WINDOW_DEPTH];
	logic [TOTAL_W-1:0] rd_data_q;
	logic [IW-1:0]      rd_addr;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      oldest_q;
	logic [SW-1:0]      sum_q;
	logic               full;
	logic [CW:0]        tail_raw;
	logic [IW-1:0]      wr_slot;

	// max scan
	logic [CW-1:0]      rem_q;
	logic [IW-1:0]      ptr_q;
	logic               vld_s1;
	logic [TOTAL_W-1:0] best_q;

	// average
	logic [TOTAL_W-1:0] avg_q;
	logic               div_busy;
	logic [SW-1:0]      quotient;

	ftws_action_t act;
	assign act = ftws_action_t'(action);

	assign total_sum = {1'b0, total_q} + {{(TOTAL_W + 1 - DUR_W){1'b0}}, duration_ns};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			fmax_q  <= '0;
			calls_q <= '0;
		end else if (cmd.exec) begin
			case (act)
				ACT_RECORD: begin
					total_q <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
					if (duration_ns > fmax_q) begin
						fmax_q <= duration_ns;
					end
					if (calls_q != CALLS_MAX) begin
						calls_q <= calls_q + 1'b1;
					end
				end
				ACT_START, ACT_CLEAR: begin
					total_q <= '0;
					fmax_q  <= '0;
					calls_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign full     = (count_q == DEPTH_C);
	assign tail_raw = {{(CW + 1 - IW){1'b0}}, oldest_q} + {1'b0, count_q};
	assign wr_slot  = full ? oldest_q
		: (tail_raw >= DEPTH_X) ? IW'(tail_raw - DEPTH_X) : IW'(tail_raw);

	// rd_data_q holds the oldest entry whenever no scan runs; a full push uses it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
		end else if (cmd.exec && act == ACT_CLEAR) begin
			count_q  <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
		end else if (cmd.push) begin
			if (full) begin
				sum_q    <= sum_q - SW'(rd_data_q) + SW'(total_q);
				oldest_q <= (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
			end else begin
				sum_q   <= sum_q + SW'(total_q);
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_slot] <= total_q;
		end
	end

	assign rd_addr = (rem_q != '0) ? ptr_q : oldest_q;

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.start) begin
			rem_q  <= count_q;
			ptr_q  <= oldest_q;
			vld_s1 <= 1'b0;
		end else if (rem_q != '0) begin
			rem_q  <= rem_q - 1'b1;
			ptr_q  <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
			vld_s1 <= 1'b1;
		end else begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cmd.start || (cmd.exec && act == ACT_CLEAR)) begin
			best_q <= '0;
		end else if (vld_s1 && rd_data_q > best_q) begin
			best_q <= rd_data_q;
		end
	end

	ftws_div #(
		.DW (SW),
		.VW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (cmd.exec && act == ACT_CLEAR) begin
			avg_q <= '0;
		end else if (cmd.load_avg) begin
			avg_q <= TOTAL_W'(quotient);
		end
	end

	assign stat.scan_done = (rem_q == '0) && !vld_s1;
	assign stat.div_done  = !div_busy;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data <= {2'b00, calls_q, fmax_q, total_q, FILL_W'(count_q), best_q, avg_q};
		end
	end

endmodule

// File: rtl/core/frame_time_window_stats.sv
// Frame time window statistics: top level.
// Per-frame duration totals plus average and maximum over a window of frame totals.
//
// Input stream: s_tuser carries the action (record, frame start, frame end,
// clear all), s_tdata the duration in ns. Every input beat yields one output beat
// on m_tdata with the window and frame statistics as they stand after that beat.
// Config: cfg_we/cfg_wdata write the enable bit; while set, frame end pushes the
// frame total into the window. Write it only while the block is idle.
// Sequencing: a beat that pushes nothing into the window goes from ST_IDLE to
// ST_EMIT, which loads the output register once it is free, and m_tvalid then
// rises; a new beat is taken only back in ST_IDLE. A frame end that pushes
// reruns the window max scan (one memory read per held entry) and the restoring
// divide for the average (one bit per cycle over the 40 + clog2(WINDOW_DEPTH+1)
// bit window sum, 46 bits at depth 60) side by side in ST_BUSY, then loads the
// average there and the output register in ST_EMIT. One item is in work at a time.
// The output register decouples the sides: the next beat is accepted while a
// result waits; if m_tready stays low the block holds its finished result and
// stops accepting. Reset clears frame counters, window fill, sum and the enable
// bit; no clearing pass over the window memory is needed.
module frame_time_window_stats #(
	parameter int WINDOW_DEPTH = ftws_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ftws_pkg::DUR_W-1:0]      s_tdata,  // [31:0] duration_ns
	input  logic [ftws_pkg::ACTION_W-1:0]   s_tuser,  // [1:0] action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [39:0] window_average_ns, [79:40] window_max_ns, [85:80] window_fill,
	// [125:86] frame_total_ns, [157:126] frame_max_ns, [173:158] frame_count
	output logic [ftws_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata
);
	import ftws_pkg::*;

	ftws_cmd_t  cmd;
	ftws_stat_t stat;

	ftws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.cmd       (cmd)
	);

	ftws_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (s_tuser),
		.duration_ns (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_data    (m_tdata)
	);

endmodule
